// File: design/ddo_pkg.sv
package ddo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int POS_WIDTH    = 32;

    localparam int XW    = 34;
    localparam int ZW    = 34;
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    localparam logic signed [XW-1:0] CORDIC_X0 = XW'(32'h26DD3B6A);
    localparam logic signed [XW-1:0] TRIG_ONE  = XW'(32'h40000000);

    localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] POS_MIN = -(64'sd1 <<< (POS_WIDTH - 1));

    localparam logic [63:0] DISP_LIMIT = 64'd1 << 62;
    localparam logic [64:0] ROUND_HALF = 65'd1 << 29;

    localparam logic [31:0] DIST_RESET = 32'd65536;
    localparam logic [31:0] TURN_RESET = 32'd65536;

    localparam logic CFG_DIST_PER_STEP = 1'b0;
    localparam logic CFG_TURN_GAIN     = 1'b1;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] set_x;
        logic signed [31:0] set_y;
        logic signed [31:0] set_heading;
    } t_odo_in;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [31:0] pose_heading;
        logic               moved;
        logic               saturated;
    } t_odo_out;

    function automatic logic [31:0] atan_val(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000029;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000003;
            5'd29:   v = 32'h00000001;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_WIDTH-1:0] clamp_pos(input logic signed [63:0] v);
        logic signed [63:0] c;
        if (v > POS_MAX) begin
            c = POS_MAX;
        end else if (v < POS_MIN) begin
            c = POS_MIN;
        end else begin
            c = v;
        end
        return c[POS_WIDTH-1:0];
    endfunction

    function automatic logic pos_over(input logic signed [63:0] v);
        return (v > POS_MAX) || (v < POS_MIN);
    endfunction

endpackage

// File: design/differential_drive_odometry_core.sv
// A moving update runs through PREP, MHEAD, MTRAV, CINIT, the CORDIC rotations in ROT, TRIG,
// MXH, MXL, SX, MYL, SY, AY and OUT; a zero-delta update goes from PREP to OUT, a load to OUT.
// A new item is taken only in IDLE, once the last one has left OUT; the CORDIC iterations run
// in ROT, and the single shared 33 x 32 multiplier serves the heading, travel and x/y products.
// Reset is synchronous and active low: pose and previous counts clear to zero and both
// configuration registers return to 65536.
module differential_drive_odometry_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ddo_pkg::t_odo_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ddo_pkg::t_odo_out o_out_data,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_addr,
    input  logic [31:0]       i_cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_PREP  = 14'b00000000000010,
        S_MHEAD = 14'b00000000000100,
        S_MTRAV = 14'b00000000001000,
        S_CINIT = 14'b00000000010000,
        S_ROT   = 14'b00000000100000,
        S_TRIG  = 14'b00000001000000,
        S_MXH   = 14'b00000010000000,
        S_MXL   = 14'b00000100000000,
        S_SX    = 14'b00001000000000,
        S_MYL   = 14'b00010000000000,
        S_SY    = 14'b00100000000000,
        S_AY    = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    logic [31:0] r_dist, r_turn;
    logic [31:0] r_prev_left, r_prev_right, r_heading;
    logic signed [POS_WIDTH-1:0] r_pos_x, r_pos_y;

    logic [31:0] r_l, r_r, r_diff;
    logic [32:0] r_abs_sum;
    logic        r_tneg, r_moved, r_sat;
    logic [63:0] r_tm;
    logic [64:0] r_prod, r_a;
    logic signed [63:0] r_disp;

    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_z;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_flip;
    logic [30:0]          r_cm, r_sm;
    logic                 r_cneg, r_sneg;

    logic     r_out_valid;
    t_odo_out r_out;

    logic [31:0] dl, dr, diff;
    logic [32:0] sum, abs_sum;
    logic        nz;
    logic [32:0] mul_a;
    logic [31:0] mul_b;

    logic signed [XW-1:0] xs, ys, fx, fy, cx_c, cy_c;
    logic signed [ZW-1:0] atan_z, z_init;
    logic                 flip;

    logic [63:0]        rr;
    logic               sneg_sel;
    logic signed [63:0] disp;
    logic signed [63:0] acc_in, acc_sum;
    logic signed [63:0] ld_x, ld_y, out_x, out_y;

    logic accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    assign dl      = r_l - r_prev_left;
    assign dr      = r_r - r_prev_right;
    assign diff    = dl - dr;
    assign nz      = (dl != 32'd0) || (dr != 32'd0);
    assign sum     = {dl[31], dl} + {dr[31], dr};
    assign abs_sum = sum[32] ? (33'd0 - sum) : sum;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MHEAD: begin
                mul_a = {1'b0, r_diff};
                mul_b = r_turn;
            end
            S_MTRAV: begin
                mul_a = r_abs_sum;
                mul_b = r_dist;
            end
            S_MXH: begin
                mul_a = {1'b0, r_tm[63:32]};
                mul_b = {1'b0, r_cm};
            end
            S_MXL: begin
                mul_a = {1'b0, r_tm[31:0]};
                mul_b = {1'b0, r_cm};
            end
            S_SX: begin
                mul_a = {1'b0, r_tm[63:32]};
                mul_b = {1'b0, r_sm};
            end
            S_MYL: begin
                mul_a = {1'b0, r_tm[31:0]};
                mul_b = {1'b0, r_sm};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign flip   = r_heading[31] ^ r_heading[30];
    assign z_init = ZW'($signed({r_heading[31] ^ flip, r_heading[30:0]}));
    assign xs     = r_cx >>> r_cnt;
    assign ys     = r_cy >>> r_cnt;
    assign atan_z = ZW'(atan_val(5'(r_cnt)));

    assign fx   = r_flip ? -r_cx : r_cx;
    assign fy   = r_flip ? -r_cy : r_cy;
    assign cx_c = (fx > TRIG_ONE) ? TRIG_ONE : ((fx < -TRIG_ONE) ? -TRIG_ONE : fx);
    assign cy_c = (fy > TRIG_ONE) ? TRIG_ONE : ((fy < -TRIG_ONE) ? -TRIG_ONE : fy);

    always_comb begin
        if (r_a[64:60] != 5'd0) begin
            rr = DISP_LIMIT;
        end else begin
            rr = {r_a[61:0], 2'b00} + 64'((r_prod + ROUND_HALF) >> 30);
            if (rr > DISP_LIMIT) begin
                rr = DISP_LIMIT;
            end
        end
    end

    assign sneg_sel = (r_state == S_SY) ? (r_tneg ^ r_sneg) : (r_tneg ^ r_cneg);
    assign disp     = sneg_sel ? -$signed(rr) : $signed(rr);

    assign acc_in  = (r_state == S_AY) ? 64'(r_pos_y) : 64'(r_pos_x);
    assign acc_sum = acc_in + r_disp;

    assign ld_x  = 64'(i_in_data.set_x);
    assign ld_y  = 64'(i_in_data.set_y);
    assign out_x = 64'(r_pos_x);
    assign out_y = 64'(r_pos_y);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_in_data.opcode == OP_LOAD) ? S_OUT : S_PREP;
                end
            end
            S_PREP:  n_state = nz ? S_MHEAD : S_OUT;
            S_MHEAD: n_state = S_MTRAV;
            S_MTRAV: n_state = S_CINIT;
            S_CINIT: n_state = S_ROT;
            S_ROT: begin
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_TRIG;
                end
            end
            S_TRIG:  n_state = S_MXH;
            S_MXH:   n_state = S_MXL;
            S_MXL:   n_state = S_SX;
            S_SX:    n_state = S_MYL;
            S_MYL:   n_state = S_SY;
            S_SY:    n_state = S_AY;
            S_AY:    n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dist       <= DIST_RESET;
            r_turn       <= TURN_RESET;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_heading    <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_out_valid  <= 1'b0;
            r_moved      <= 1'b0;
            r_sat        <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    CFG_DIST_PER_STEP: r_dist <= i_cfg_data;
                    CFG_TURN_GAIN:     r_turn <= i_cfg_data;
                    default: ;
                endcase
            end

            if ((r_state == S_OUT) && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_moved <= 1'b0;
                        if (i_in_data.opcode == OP_LOAD) begin
                            r_pos_x   <= clamp_pos(ld_x);
                            r_pos_y   <= clamp_pos(ld_y);
                            r_heading <= i_in_data.set_heading;
                            r_sat     <= pos_over(ld_x) || pos_over(ld_y);
                        end else begin
                            r_sat <= 1'b0;
                        end
                    end
                end
                S_PREP: begin
                    if (nz) begin
                        r_moved      <= 1'b1;
                        r_prev_left  <= r_l;
                        r_prev_right <= r_r;
                    end
                end
                S_MTRAV: begin
                    r_heading <= r_heading + r_prod[31:0];
                end
                S_MYL: begin
                    r_pos_x <= clamp_pos(acc_sum);
                    if (pos_over(acc_sum)) begin
                        r_sat <= 1'b1;
                    end
                end
                S_AY: begin
                    r_pos_y <= clamp_pos(acc_sum);
                    if (pos_over(acc_sum)) begin
                        r_sat <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        case (r_state)
            S_IDLE: begin
                r_l <= i_in_data.left_count;
                r_r <= i_in_data.right_count;
            end
            S_PREP: begin
                r_diff    <= diff;
                r_abs_sum <= abs_sum;
                r_tneg    <= sum[32];
            end
            S_CINIT: begin
                r_tm   <= r_prod[64:1];
                r_cx   <= CORDIC_X0;
                r_cy   <= '0;
                r_z    <= z_init;
                r_flip <= flip;
                r_cnt  <= '0;
            end
            S_ROT: begin
                if (!r_z[ZW-1]) begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_z  <= r_z - atan_z;
                end else begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_z  <= r_z + atan_z;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            S_TRIG: begin
                r_cneg <= cx_c[XW-1];
                r_sneg <= cy_c[XW-1];
                r_cm   <= cx_c[XW-1] ? 31'(-cx_c) : 31'(cx_c);
                r_sm   <= cy_c[XW-1] ? 31'(-cy_c) : 31'(cy_c);
            end
            S_MXL: r_a <= r_prod;
            S_SX:  r_disp <= disp;
            S_MYL: r_a <= r_prod;
            S_SY:  r_disp <= disp;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.pose_x       <= out_x[31:0];
                    r_out.pose_y       <= out_y[31:0];
                    r_out.pose_heading <= r_heading;
                    r_out.moved        <= r_moved;
                    r_out.saturated    <= r_sat;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/sv/tb_differential_drive_odometry_core.sv
module tb_differential_drive_odometry_core;

    import ddo_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PER_PHASE = 240;
    localparam int ERROR_PRINT_CAP = 30;

    localparam logic [31:0] ANGLE_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic        op;
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] head;
        logic        pinned;
        logic [31:0] want_x;
        logic [31:0] want_y;
        logic [31:0] want_head;
    } t_dir_row;

    typedef struct {
        logic     pinned;
        t_odo_out want;
    } t_pin;

    // Pinned rows always expect moved and saturated to be low.
    localparam t_dir_row DIRECTED [20] = '{
        '{OP_UPDATE, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
        '{OP_LOAD, 32'h00000000, 32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000,
          1'b1, 32'h7FFFFFFF, 32'h80000000, 32'h00000000},
        '{OP_UPDATE, 32'h00000001, 32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b1, 32'h00000000, 32'h00000000, 32'h00000000},
        '{OP_UPDATE, 32'h00000002, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_UPDATE, 32'h00000002, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h40000000,
          1'b1, 32'h80000000, 32'h7FFFFFFF, 32'h40000000},
        '{OP_UPDATE, 32'h000003E8, 32'h000003E8, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_UPDATE, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_UPDATE, 32'h80000000, 32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000,
          1'b1, 32'h00000000, 32'h00000000, 32'h80000000},
        '{OP_UPDATE, 32'h80000005, 32'h80000004, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'h00000000, 32'h00000000, 32'h00010000, 32'hFFFF0000, 32'hC0000000,
          1'b1, 32'h00010000, 32'hFFFF0000, 32'hC0000000},
        '{OP_UPDATE, 32'h80000000, 32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'h00000000, 32'h00000000, 32'h12345678, 32'hEDCBA987, 32'hBFFFFFFF,
          1'b1, 32'h12345678, 32'hEDCBA987, 32'hBFFFFFFF},
        '{OP_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
          1'b0, 32'h0, 32'h0, 32'h0},
        '{OP_LOAD, 32'h12345678, 32'h9ABCDEF0, 32'h00000000, 32'h00000000, 32'h3FFFFFFF,
          1'b1, 32'h00000000, 32'h00000000, 32'h3FFFFFFF},
        '{OP_UPDATE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b1, 32'h00000000, 32'h00000000, 32'h3FFFFFFF},
        '{OP_UPDATE, 32'h7FFFFFFE, 32'h80000000, 32'h00000000, 32'h00000000, 32'h00000000,
          1'b0, 32'h0, 32'h0, 32'h0}
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    t_odo_in  in_data   = '0;
    logic     out_ready = 1'b0;
    logic     cfg_wr_en = 1'b0;
    logic     cfg_addr  = 1'b0;
    logic     [31:0] cfg_data = '0;
    logic     o_in_ready;
    logic     o_out_valid;
    t_odo_out o_out_data;

    logic [31:0] step_dist;
    logic [31:0] step_turn;
    logic [31:0] odo_prev_l;
    logic [31:0] odo_prev_r;
    logic [31:0] odo_head;
    longint      odo_x;
    longint      odo_y;

    logic [31:0] gen_l;
    logic [31:0] gen_r;

    t_odo_out pose_expected_q [$];
    t_pin     pin_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int n_errors       = 0;
    int n_cmds         = 0;
    int n_loads        = 0;
    int n_results      = 0;
    int n_moved        = 0;
    int n_saturated    = 0;
    int n_settings     = 1;

    t_odo_out pred_pose;
    t_odo_out want_pose;
    t_pin     cur_pin;

    differential_drive_odometry_core u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_span(input longint v, inout logic hit);
        longint lim;
        lim = 64'sd1 <<< (POS_WIDTH - 1);
        if (v > lim - 1) begin
            hit = 1'b1;
            return lim - 1;
        end
        if (v < -lim) begin
            hit = 1'b1;
            return -lim;
        end
        return v;
    endfunction

    function automatic void heading_trig(input logic [31:0] ang, output longint c,
                                         output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        longint      xs;
        longint      ys;
        flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        a = flip ? ang + 32'h80000000 : ang;
        x = 64'sh26DD3B6A;
        y = 0;
        z = longint'($signed(a));
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                t = x - ys;
                y = y + xs;
                z = z - longint'(ANGLE_STEP[i]);
            end else begin
                t = x + ys;
                y = y - xs;
                z = z + longint'(ANGLE_STEP[i]);
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        if (x > 64'sd1073741824) x = 64'sd1073741824;
        if (x < -64'sd1073741824) x = -64'sd1073741824;
        if (y > 64'sd1073741824) y = 64'sd1073741824;
        if (y < -64'sd1073741824) y = -64'sd1073741824;
        c = x;
        s = y;
    endfunction

    function automatic longint travel_part(input logic [63:0] tm, input logic tneg,
                                           input longint f);
        logic        neg;
        logic [63:0] c;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        neg = tneg != (f < 0);
        c = (f < 0) ? -f : f;
        a = (tm >> 32) * c;
        b = {32'b0, tm[31:0]} * c;
        r = (a << 2) + ((b + (64'd1 << 29)) >> 30);
        if (a[63:60] != 4'b0 || r > (64'd1 << 62)) r = 64'd1 << 62;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic t_odo_out odometry_step(input t_odo_in cmd);
        t_odo_out    res;
        logic        sat;
        logic        moved;
        logic        tneg;
        logic [31:0] dlu;
        logic [31:0] dru;
        logic [63:0] mag;
        logic [63:0] tm;
        longint      dl;
        longint      dr;
        longint      sum;
        longint      c;
        longint      s;
        sat = 1'b0;
        moved = 1'b0;
        if (cmd.opcode == OP_LOAD) begin
            odo_x = clamp_span(longint'(cmd.set_x), sat);
            odo_y = clamp_span(longint'(cmd.set_y), sat);
            odo_head = cmd.set_heading;
        end else begin
            dlu = cmd.left_count - odo_prev_l;
            dru = cmd.right_count - odo_prev_r;
            dl = longint'($signed(dlu));
            dr = longint'($signed(dru));
            if (dl != 0 || dr != 0) begin
                moved = 1'b1;
                sum = dl + dr;
                tneg = sum < 0;
                odo_prev_l = cmd.left_count;
                odo_prev_r = cmd.right_count;
                odo_head = odo_head + (dlu - dru) * step_turn;
                mag = tneg ? -sum : sum;
                tm = (mag * {32'b0, step_dist}) >> 1;
                heading_trig(odo_head, c, s);
                odo_x = clamp_span(odo_x + travel_part(tm, tneg, c), sat);
                odo_y = clamp_span(odo_y + travel_part(tm, tneg, s), sat);
            end
        end
        res.pose_x = odo_x[31:0];
        res.pose_y = odo_y[31:0];
        res.pose_heading = odo_head;
        res.moved = moved;
        res.saturated = sat;
        return res;
    endfunction

    function automatic t_odo_in next_random_cmd();
        t_odo_in cmd;
        int      k;
        int      span;
        k = $urandom_range(0, 99);
        cmd.opcode = OP_UPDATE;
        cmd.left_count = $urandom;
        cmd.right_count = $urandom;
        cmd.set_x = $urandom;
        cmd.set_y = $urandom;
        cmd.set_heading = $urandom;
        if (k < 10) begin
            cmd.opcode = OP_LOAD;
            if ($urandom_range(0, 1) == 1) begin
                cmd.set_x = cmd.set_x >>> 12;
                cmd.set_y = cmd.set_y >>> 12;
            end
        end else if (k < 20) begin
            cmd.left_count = gen_l;
            cmd.right_count = gen_r;
        end else if (k < 28) begin
            gen_l = cmd.left_count;
            gen_r = cmd.right_count;
        end else begin
            span = ($urandom_range(0, 9) < 7) ? 64 : 65535;
            gen_l = gen_l + ($urandom_range(0, 2 * span) - span);
            if ($urandom_range(0, 99) >= 15) begin
                gen_r = gen_r + ($urandom_range(0, 2 * span) - span);
            end
            cmd.left_count = gen_l;
            cmd.right_count = gen_r;
        end
        return cmd;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            if (n_errors <= ERROR_PRINT_CAP) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    task automatic send_pose_cmd(input t_odo_in cmd, input logic pin_en,
                                 input t_odo_out pin_val);
        pin_q.push_back('{pinned: pin_en, want: pin_val});
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pose_expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_config(input logic [31:0] dist_val, input logic [31:0] turn);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DIST_PER_STEP;
        cfg_data  <= dist_val;
        @(posedge clk);
        cfg_addr  <= CFG_TURN_GAIN;
        cfg_data  <= turn;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_dist = dist_val;
        step_turn = turn;
        n_settings++;
    endtask

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && in_valid && o_in_ready) begin
            pred_pose = odometry_step(in_data);
            cur_pin = pin_q.pop_front();
            pose_expected_q.push_back(cur_pin.pinned ? cur_pin.want : pred_pose);
            n_cmds++;
            if (in_data.opcode == OP_LOAD) n_loads++;
        end
    end

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            n_results++;
            if (pose_expected_q.size() == 0) begin
                n_errors++;
                if (n_errors <= ERROR_PRINT_CAP) begin
                    $display("%0t: unexpected result, expected none, got %h", $time,
                             o_out_data);
                end
            end else begin
                want_pose = pose_expected_q.pop_front();
                check_field("pose_x", want_pose.pose_x, o_out_data.pose_x);
                check_field("pose_y", want_pose.pose_y, o_out_data.pose_y);
                check_field("pose_heading", want_pose.pose_heading, o_out_data.pose_heading);
                check_field("moved", 32'(want_pose.moved), 32'(o_out_data.moved));
                check_field("saturated", 32'(want_pose.saturated), 32'(o_out_data.saturated));
                if (o_out_data.moved) n_moved++;
                if (o_out_data.saturated) n_saturated++;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_odo_in     cmd;
        t_odo_out    want;
        logic [31:0] step_len;
        logic [31:0] turn;
        step_dist = 32'd65536;
        step_turn = 32'd65536;
        odo_prev_l = '0;
        odo_prev_r = '0;
        odo_head = '0;
        odo_x = 0;
        odo_y = 0;
        gen_l = '0;
        gen_r = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) begin
            cmd = '{opcode: DIRECTED[i].op, left_count: DIRECTED[i].left,
                    right_count: DIRECTED[i].right, set_x: DIRECTED[i].x,
                    set_y: DIRECTED[i].y, set_heading: DIRECTED[i].head};
            want = '{pose_x: DIRECTED[i].want_x, pose_y: DIRECTED[i].want_y,
                     pose_heading: DIRECTED[i].want_head, moved: 1'b0, saturated: 1'b0};
            send_pose_cmd(cmd, DIRECTED[i].pinned, want);
            if (DIRECTED[i].op == OP_UPDATE) begin
                gen_l = DIRECTED[i].left;
                gen_r = DIRECTED[i].right;
            end
        end

        for (int ph = 1; ph <= 5; ph++) begin
            settle();
            case (ph)
                1: begin
                    step_len = 32'd65536;
                    turn = 32'h00100000;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                2: begin
                    step_len = 32'h00000000;
                    turn = 32'hFFFFFFFF;
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                3: begin
                    step_len = 32'hFFFFFFFF;
                    turn = 32'h00000000;
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                4: begin
                    step_len = $urandom_range(1, 32'h00200000);
                    turn = $urandom;
                    send_idle_pct = 11;
                    recv_stall_pct = 11;
                end
                default: begin
                    step_len = 32'h00008000;
                    turn = 32'h00010000;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            write_config(step_len, turn);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Hold the sender back until the block has drained completely.
                if (ph == 3 && n == RANDOM_PER_PHASE / 2) settle();
                send_pose_cmd(next_random_cmd(), 1'b0, '0);
            end
        end

        settle();
        repeat (2 * CORDIC_STEPS + 16) @(posedge clk);
        if (pose_expected_q.size() != 0) begin
            n_errors++;
            $display("%0t: %0d results still outstanding", $time, pose_expected_q.size());
        end

        $display("Sent %0d commands (%0d pose loads) under %0d register settings.",
                 n_cmds, n_loads, n_settings);
        $display("Checked %0d poses: %0d moved, %0d saturated, %0d mismatches.",
                 n_results, n_moved, n_saturated, n_errors);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/ddo_pkg.sv
design/differential_drive_odometry_core.sv
tb/sv/tb_differential_drive_odometry_core.sv
